// ----- rtl/core/iiel_pkg.sv -----
// Package for the indexed insert/erase list: sizes, action and status codes,
// payload structs and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package iiel_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;

  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ACT_W  = 3;
  localparam int POS_W  = 5;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [ACT_W-1:0] ACT_APPEND = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ERASE  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_FIRST  = 3'd4;
  localparam logic [ACT_W-1:0] ACT_LAST   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] OP_NONE   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_ERASE  = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] SEL_POS   = 2'd0;
  localparam logic [1:0] SEL_ZERO  = 2'd1;
  localparam logic [1:0] SEL_LAST  = 2'd2;
  localparam logic [1:0] SEL_COUNT = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0]  read_value;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  count;
  } out_word_t;

  typedef struct packed {
    logic              load;
    logic [1:0]        op;
    logic [1:0]        sel;
    logic [STAT_W-1:0] status;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_le_cnt;
    logic pos_lt_cnt;
  } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/core/indexed_insert_erase_list.sv -----
// Every word is executed in the cycle it is accepted: the whole chain of cells
// shifts at once for insert and erase, and the result lands in an output
// register in the cycle after acceptance. A new word is taken whenever the output
// register is empty or is being drained in the same cycle, so with out_ready
// held high the list sustains one word per clock.
// Reads of the list are only ever made below the current count.
// Top level of the indexed insert/erase list; depends on iiel_pkg, iiel_ctrl
// and iiel_dp.
`default_nettype none

module indexed_insert_erase_list import iiel_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_word_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_word_t      out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  iiel_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (in_data.action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  iiel_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .position (in_data.position),
    .value    (in_data.value),
    .cmd      (cmd),
    .stat     (stat),
    .result   (out_data)
  );

`ifndef NO_ASSERTIONS
  // A full status can only be reported with the list at capacity.
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> (out_data.count == POS_W'(DEPTH)))
    else $error("full status with list below capacity");

  // An empty status can only be reported with no entries stored.
  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> (out_data.count == '0))
    else $error("empty status with entries stored");

  // Every accepted word yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted word produced no result");

  // The list only changes size when a word is accepted.
  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cmd.load) |-> (stat.empty == $past(stat.empty) || !$past(rst_n)))
    else $error("list size changed without an accepted word");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/iiel_ctrl.sv -----
// Controller for the indexed insert/erase list: handshake state machine and
// action decode into datapath commands. Depends on iiel_pkg.
`default_nettype none

module iiel_ctrl import iiel_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [ACT_W-1:0] action,
  output logic                  out_valid,
  input  wire logic             out_ready,
  input  wire dp_stat_t         stat,
  output dp_cmd_t               cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_HOLD = 1'b1;

  logic state_r, state_nxt;
  logic accept;

  assign out_valid = (state_r == S_HOLD);
  assign in_ready  = (state_r == S_IDLE) || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      state_nxt = S_HOLD;
    end else if (out_ready) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Index checks come before the full check, as insert past the end is a bad index.
  always_comb begin
    cmd.load   = accept;
    cmd.op     = OP_NONE;
    cmd.sel    = SEL_POS;
    cmd.status = ST_OK;
    case (action)
      ACT_APPEND: begin
        if (stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op  = OP_INSERT;
          cmd.sel = SEL_COUNT;
        end
      end
      ACT_INSERT: begin
        if (!stat.pos_le_cnt) begin
          cmd.status = ST_BAD_INDEX;
        end else if (stat.full) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.op = OP_INSERT;
        end
      end
      ACT_ERASE: begin
        if (!stat.pos_lt_cnt) begin
          cmd.status = ST_BAD_INDEX;
        end else begin
          cmd.op = OP_ERASE;
        end
      end
      ACT_READ: begin
        if (!stat.pos_lt_cnt) begin
          cmd.status = ST_BAD_INDEX;
        end else begin
          cmd.op = OP_READ;
        end
      end
      ACT_FIRST: begin
        if (stat.empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.op  = OP_READ;
          cmd.sel = SEL_ZERO;
        end
      end
      ACT_LAST: begin
        if (stat.empty) begin
          cmd.status = ST_EMPTY;
        end else begin
          cmd.op  = OP_READ;
          cmd.sel = SEL_LAST;
        end
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/iiel_dp.sv -----
// Datapath for the indexed insert/erase list: the shifting chain of cells,
// the entry count and the result register. Depends on iiel_pkg.
`default_nettype none

module iiel_dp import iiel_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [POS_W-1:0] position,
  input  wire logic [VAL_W-1:0] value,
  input  wire dp_cmd_t          cmd,
  output dp_stat_t              stat,
  output out_word_t             result
);

  logic [DATA_WIDTH-1:0] cell_r [DEPTH];
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [IDX_W-1:0]      idx;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH-1:0] rd_word;
  out_word_t             result_r, result_nxt;
  logic                  do_insert, do_erase;

  assign word      = DATA_WIDTH'(value);
  assign do_insert = cmd.load && (cmd.op == OP_INSERT);
  assign do_erase  = cmd.load && (cmd.op == OP_ERASE);

  assign stat.empty      = (count_r == '0);
  assign stat.full       = (count_r == CNT_W'(DEPTH));
  assign stat.pos_le_cnt = (CMP_W'(position) <= CMP_W'(count_r));
  assign stat.pos_lt_cnt = (CMP_W'(position) <  CMP_W'(count_r));

  always_comb begin
    case (cmd.sel)
      SEL_POS:   idx = IDX_W'(position);
      SEL_ZERO:  idx = '0;
      SEL_LAST:  idx = IDX_W'(count_r - CNT_W'(1));
      SEL_COUNT: idx = IDX_W'(count_r);
      default:   idx = '0;
    endcase
  end

  // Insert shifts the cells above idx up; erase shifts the cells from idx down.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (do_insert) begin
        if (IDX_W'(i) == idx) begin
          cell_r[i] <= word;
        end else if ((i > 0) && (IDX_W'(i) > idx)) begin
          cell_r[i] <= cell_r[(i > 0) ? i - 1 : 0];
        end
      end else if (do_erase) begin
        if ((i < DEPTH - 1) && (IDX_W'(i) >= idx)) begin
          cell_r[i] <= cell_r[(i < DEPTH - 1) ? i + 1 : i];
        end
      end
    end
  end

  assign rd_word = cell_r[idx];

  always_comb begin
    count_nxt = count_r;
    if (do_insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_erase) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    result_nxt.read_value = (cmd.op == OP_READ) ? VAL_W'(rd_word) : '0;
    result_nxt.status     = cmd.status;
    result_nxt.count      = POS_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      result_r <= result_nxt;
    end
  end

  assign result = result_r;

endmodule

`default_nettype wire
